// ----- hdl/wivs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wivs_pkg
// Shared constants, codes and controller/datapath link types for the
// windowed identity vote smoother.
// ----------------------------------------------------------------------------
package wivs_pkg;

    // default sizing
    localparam int WINDOW_MAX_DEF = 8;
    localparam int ID_BITS_DEF    = 8;
    localparam int SCORE_BITS_DEF = 16;

    // fixed field widths
    localparam int VOTE_BITS     = 4;
    localparam int WLEN_BITS     = 4;
    localparam int MINV_BITS     = 4;
    localparam int THR_BITS      = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // register reset values
    localparam logic [WLEN_BITS-1:0]       WLEN_RST = 4'd5;
    localparam logic [MINV_BITS-1:0]       MINV_RST = 4'd3;
    localparam logic signed [THR_BITS-1:0] THR_RST  = 16'sd16384;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_VOTES        = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACCEPT_THRESHOLD = 2'd2;

    // item action codes
    localparam logic ACT_RECORD = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OUTER,
        S_OUTER_WAIT,
        S_INNER,
        S_DIV_START,
        S_DIV_WAIT,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic record;       // write candidate, advance ring, reset search
        logic clear;        // empty the window
        logic outer_rd;     // read newest-minus-i entry
        logic skip;         // unknown entry, next i
        logic inner_init;   // latch candidate id, clear tallies
        logic inner_rd;     // read newest-minus-j entry, next j
        logic div_start;    // start average division
        logic best_update;  // compare with best, next i
        logic out_load;     // load result register
    } dp_cmd_t;

    typedef struct packed {
        logic outer_done;
        logic inner_done;
        logic id_zero;
        logic div_done;
    } dp_status_t;

endpackage

// ----- hdl/wivs_item_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wivs_item_if
// Input item channel: record or clear request with ids and score.
// ----------------------------------------------------------------------------
interface wivs_item_if import wivs_pkg::*; #(
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int SCORE_BITS = SCORE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [ID_BITS-1:0]           matched_id;
    logic [ID_BITS-1:0]           nearest_id;
    logic signed [SCORE_BITS-1:0] match_score;

    modport source (
        output valid, action, matched_id, nearest_id, match_score,
        input  ready
    );
    modport sink (
        input  valid, action, matched_id, nearest_id, match_score,
        output ready
    );
endinterface

// ----- hdl/wivs_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wivs_result_if
// Result channel: vote winner, its votes, its average and the verdict.
// ----------------------------------------------------------------------------
interface wivs_result_if import wivs_pkg::*; #(
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int SCORE_BITS = SCORE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         accepted;
    logic [ID_BITS-1:0]           winner_id;
    logic [VOTE_BITS-1:0]         winner_votes;
    logic signed [SCORE_BITS-1:0] winner_average;

    modport source (
        output valid, accepted, winner_id, winner_votes, winner_average,
        input  ready
    );
    modport sink (
        input  valid, accepted, winner_id, winner_votes, winner_average,
        output ready
    );
endinterface

// ----- hdl/wivs_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wivs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wivs_cfg_if import wivs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- hdl/wivs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wivs_div
// Serial restoring divider, one quotient bit per cycle; signed dividend,
// unsigned nonzero divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module wivs_div import wivs_pkg::*; #(
    parameter int SUM_BITS   = SCORE_BITS_DEF + $clog2(WINDOW_MAX_DEF + 1),
    parameter int CNT_BITS   = $clog2(WINDOW_MAX_DEF + 1),
    parameter int SCORE_BITS = SCORE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [SUM_BITS-1:0]   dividend,
    input  logic [CNT_BITS-1:0]          divisor,
    output logic                         done,
    output logic signed [SCORE_BITS-1:0] quotient
);

    localparam int STEP_BITS = $clog2(SUM_BITS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [SUM_BITS-1:0]  mag_reg;
    logic [CNT_BITS-1:0]  rem_reg;
    logic [CNT_BITS-1:0]  den_reg;
    logic                 neg_reg;

    logic [CNT_BITS:0]    shifted;
    logic                 fits;
    logic [CNT_BITS-1:0]  rem_next;
    logic [SUM_BITS-1:0]  q_signed;

    always_comb
    begin
        shifted  = {rem_reg, mag_reg[SUM_BITS-1]};
        fits     = (shifted >= {1'b0, den_reg});
        rem_next = fits ? CNT_BITS'(shifted - {1'b0, den_reg}) : CNT_BITS'(shifted);
        q_signed = neg_reg ? (SUM_BITS'(0) - mag_reg) : mag_reg;
    end

    assign done     = done_reg;
    assign quotient = signed'(q_signed[SCORE_BITS-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_BITS'(SUM_BITS);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_BITS-1];
            mag_reg <= dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            mag_reg <= {mag_reg[SUM_BITS-2:0], fits};
        end
    end

endmodule

// ----- hdl/wivs_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wivs_datapath
// History ring memory, configuration registers, vote tallies, best-winner
// registers, average divider and result register.
// ----------------------------------------------------------------------------
module wivs_datapath import wivs_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int SCORE_BITS = SCORE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data,
    input  logic [ID_BITS-1:0]           matched_id,
    input  logic [ID_BITS-1:0]           nearest_id,
    input  logic signed [SCORE_BITS-1:0] match_score,
    input  dp_cmd_t                      cmd,
    output dp_status_t                   status,
    output logic                         res_accepted,
    output logic [ID_BITS-1:0]           res_winner_id,
    output logic [VOTE_BITS-1:0]         res_winner_votes,
    output logic signed [SCORE_BITS-1:0] res_winner_average
);

    localparam int CNT_BITS = $clog2(WINDOW_MAX + 1);
    localparam int PTR_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int IW       = CNT_BITS + 1;
    localparam int SUM_BITS = SCORE_BITS + CNT_BITS;
    localparam int CW       = (CNT_BITS > WLEN_BITS) ? CNT_BITS : WLEN_BITS;
    localparam int CMP_BITS = (SCORE_BITS > THR_BITS) ? SCORE_BITS : THR_BITS;

    // ring memory
    logic [ID_BITS-1:0]           mem_id    [WINDOW_MAX];
    logic signed [SCORE_BITS-1:0] mem_score [WINDOW_MAX];

    // configuration
    logic [WLEN_BITS-1:0]         wlen_reg;
    logic [MINV_BITS-1:0]         minv_reg;
    logic signed [THR_BITS-1:0]   thr_reg;

    // ring control
    logic [PTR_BITS-1:0]          wp_reg;
    logic [CNT_BITS-1:0]          occ_reg;
    logic [CNT_BITS-1:0]          i_reg;
    logic [CNT_BITS-1:0]          j_reg;
    logic                         acc_vld_reg;

    // read data and tallies
    logic [ID_BITS-1:0]           rd_id_reg;
    logic signed [SCORE_BITS-1:0] rd_score_reg;
    logic [ID_BITS-1:0]           cur_id_reg;
    logic signed [SUM_BITS-1:0]   sum_reg;
    logic [CNT_BITS-1:0]          votes_reg;
    logic [ID_BITS-1:0]           best_id_reg;
    logic [CNT_BITS-1:0]          lead_votes_reg;
    logic signed [SCORE_BITS-1:0] best_avg_reg;

    // result register
    logic                         out_acc_reg;
    logic [ID_BITS-1:0]           out_id_reg;
    logic [VOTE_BITS-1:0]         out_votes_reg;
    logic signed [SCORE_BITS-1:0] out_avg_reg;

    logic [CW-1:0]                wlen_ext;
    logic [CNT_BITS-1:0]          win;
    logic [IW-1:0]                occ_inc;
    logic [CNT_BITS-1:0]          occ_next;
    logic [PTR_BITS-1:0]          wp_next;
    logic [ID_BITS-1:0]           cand;
    logic [PTR_BITS-1:0]          rd_addr;
    logic                         rd_en;
    logic                         div_done;
    logic signed [SCORE_BITS-1:0] div_q;
    logic                         better;
    logic                         pass;

    // slot k entries back from the newest
    function automatic logic [PTR_BITS-1:0] slot_of(
        input logic [PTR_BITS-1:0] wp,
        input logic [CNT_BITS-1:0] k
    );
        logic [IW-1:0] t;
        t = IW'(wp) + IW'(WINDOW_MAX - 1) - IW'(k);
        if (t >= IW'(WINDOW_MAX))
            t = t - IW'(WINDOW_MAX);
        return t[PTR_BITS-1:0];
    endfunction

    always_comb
    begin
        wlen_ext = CW'(wlen_reg);
        if (wlen_ext == '0)
            win = CNT_BITS'(1);
        else if (wlen_ext > CW'(WINDOW_MAX))
            win = CNT_BITS'(WINDOW_MAX);
        else
            win = CNT_BITS'(wlen_ext);

        occ_inc  = IW'(occ_reg) + IW'(1);
        occ_next = (occ_inc > IW'(win)) ? win : CNT_BITS'(occ_inc);
        wp_next  = (wp_reg == PTR_BITS'(WINDOW_MAX - 1)) ? '0 : wp_reg + 1'b1;
        cand     = (matched_id != '0) ? matched_id : nearest_id;

        rd_en    = cmd.outer_rd || cmd.inner_rd;
        rd_addr  = cmd.outer_rd ? slot_of(wp_reg, i_reg) : slot_of(wp_reg, j_reg);

        better = (votes_reg > lead_votes_reg)
              || ((votes_reg == lead_votes_reg) && (div_q > best_avg_reg))
              || ((votes_reg == lead_votes_reg) && (div_q == best_avg_reg)
                  && (cur_id_reg < best_id_reg));

        pass = (best_id_reg != '0)
            && (CW'(lead_votes_reg) >= CW'(minv_reg))
            && (CMP_BITS'(best_avg_reg) >= CMP_BITS'(thr_reg));

        status.outer_done = (i_reg == occ_reg);
        status.inner_done = (j_reg == occ_reg);
        status.id_zero    = (rd_id_reg == '0);
        status.div_done   = div_done;
    end

    wivs_div #(
        .SUM_BITS   (SUM_BITS),
        .CNT_BITS   (CNT_BITS),
        .SCORE_BITS (SCORE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (votes_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // ring memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.record)
        begin
            mem_id[wp_reg]    <= cand;
            mem_score[wp_reg] <= match_score;
        end
        if (rd_en)
        begin
            rd_id_reg    <= mem_id[rd_addr];
            rd_score_reg <= mem_score[rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg    <= WLEN_RST;
            minv_reg    <= MINV_RST;
            thr_reg     <= THR_RST;
            wp_reg      <= '0;
            occ_reg     <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            acc_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    CFG_WINDOW_LENGTH:    wlen_reg <= WLEN_BITS'(cfg_data);
                    CFG_MIN_VOTES:        minv_reg <= MINV_BITS'(cfg_data);
                    CFG_ACCEPT_THRESHOLD: thr_reg  <= signed'(THR_BITS'(cfg_data));
                    default:              ;
                endcase
            end

            acc_vld_reg <= cmd.inner_rd;

            if (cmd.clear)
            begin
                wp_reg  <= '0;
                occ_reg <= '0;
            end
            else if (cmd.record)
            begin
                wp_reg  <= wp_next;
                occ_reg <= occ_next;
            end

            if (cmd.record)
                i_reg <= '0;
            else if (cmd.skip || cmd.best_update)
                i_reg <= i_reg + 1'b1;

            if (cmd.inner_init)
                j_reg <= '0;
            else if (cmd.inner_rd)
                j_reg <= j_reg + 1'b1;
        end
    end

    // tallies, best winner, result payload
    always_ff @(posedge clk)
    begin
        if (cmd.inner_init)
        begin
            cur_id_reg <= rd_id_reg;
            sum_reg    <= '0;
            votes_reg  <= '0;
        end
        else if (acc_vld_reg && (rd_id_reg == cur_id_reg))
        begin
            sum_reg   <= sum_reg + SUM_BITS'(rd_score_reg);
            votes_reg <= votes_reg + 1'b1;
        end

        if (cmd.record)
        begin
            best_id_reg    <= '0;
            lead_votes_reg <= '0;
            best_avg_reg   <= '0;
        end
        else if (cmd.best_update && better)
        begin
            best_id_reg    <= cur_id_reg;
            lead_votes_reg <= votes_reg;
            best_avg_reg   <= div_q;
        end

        if (cmd.out_load)
        begin
            out_acc_reg   <= pass;
            out_id_reg    <= best_id_reg;
            out_votes_reg <= VOTE_BITS'(lead_votes_reg);
            out_avg_reg   <= best_avg_reg;
        end
    end

    assign res_accepted       = out_acc_reg;
    assign res_winner_id      = out_id_reg;
    assign res_winner_votes   = out_votes_reg;
    assign res_winner_average = out_avg_reg;

endmodule

// ----- hdl/wivs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wivs_ctrl
// Sequencer for the vote search: outer walk over window entries, inner
// tally pass, division, best update; owns the result valid flag.
// ----------------------------------------------------------------------------
module wivs_ctrl import wivs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_action,
    output logic       item_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        item_ready     = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    if (item_action == ACT_CLEAR)
                        cmd.clear = 1'b1;
                    else
                    begin
                        cmd.record = 1'b1;
                        state_next = S_OUTER;
                    end
                end
            end
            S_OUTER:
            begin
                if (status.outer_done)
                    state_next = S_FINISH;
                else
                begin
                    cmd.outer_rd = 1'b1;
                    state_next   = S_OUTER_WAIT;
                end
            end
            S_OUTER_WAIT:
            begin
                if (status.id_zero)
                begin
                    cmd.skip   = 1'b1;
                    state_next = S_OUTER;
                end
                else
                begin
                    cmd.inner_init = 1'b1;
                    state_next     = S_INNER;
                end
            end
            S_INNER:
            begin
                // last tally lands in the cycle that sees inner_done
                if (status.inner_done)
                    state_next = S_DIV_START;
                else
                    cmd.inner_rd = 1'b1;
            end
            S_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.best_update = 1'b1;
                    state_next      = S_OUTER;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/windowed_identity_vote_smoother.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_identity_vote_smoother
// Sliding-window majority vote over per-frame identity results, with
// average-similarity tie break (then lower id) and acceptance test.
// ----------------------------------------------------------------------------
//
//  channel  dir  transfer when     payload
//  -------  ---  ----------------  -------------------------------------------
//  item     in   valid && ready    action, matched_id, nearest_id, match_score
//  result   out  valid && ready    accepted, winner_id, winner_votes,
//                                  winner_average
//  cfg      in   valid && ready    index, data (ready is always high)
//
//  A clear item gives no result. A record item runs an outer walk over
//  the window entries after insertion and, for each known one, an inner
//  tally pass over all of them on the single ring read port and one run
//  of the one-bit-per-cycle average divider.
//  Reset: window empty, registers at their reset values; ring contents are
//  not cleared, only written entries are ever read.
//  Stalls: one item at a time; a finished result waits in the output
//  register while the next item is taken, and the block only holds in its
//  last step if that register is still occupied.
//
module windowed_identity_vote_smoother import wivs_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int SCORE_BITS = SCORE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    wivs_item_if.sink     item,
    wivs_result_if.source result,
    wivs_cfg_if.sink      cfg
);

    // controller <-> datapath link
    dp_cmd_t    cmd;
    dp_status_t status;

    // config writes are to be issued only while idle (the user's duty, not enforced here); never back-pressured
    assign cfg.ready = 1'b1;

    wivs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_action (item.action),
        .item_ready  (item.ready),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .status      (status),
        .cmd         (cmd)
    );

    // ring, tallies, divider and result payload
    wivs_datapath #(
        .WINDOW_MAX (WINDOW_MAX),
        .ID_BITS    (ID_BITS),
        .SCORE_BITS (SCORE_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr             (cfg.valid && cfg.ready),
        .cfg_index          (cfg.index),
        .cfg_data           (cfg.data),
        .matched_id         (item.matched_id),
        .nearest_id         (item.nearest_id),
        .match_score        (item.match_score),
        .cmd                (cmd),
        .status             (status),
        .res_accepted       (result.accepted),
        .res_winner_id      (result.winner_id),
        .res_winner_votes   (result.winner_votes),
        .res_winner_average (result.winner_average)
    );

    // a clear transfer leaves the block idle and ready again
    a_clear_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.action == ACT_CLEAR) |=> item.ready)
        else $error("clear item left the block busy");

    // a record transfer starts the search
    a_record_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.action == ACT_RECORD) |=> !item.ready)
        else $error("record item did not start the search");

    // the result register is never overwritten while a result waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!result.valid || result.ready))
        else $error("pending result overwritten");

    // an accepted verdict always names a known winner
    a_accept_has_winner: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.accepted) |-> (result.winner_id != '0))
        else $error("accepted result without a winner");

endmodule

// ----- tb/sv/windowed_identity_vote_smoother_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_identity_vote_smoother_test
// Self-checking bench for the windowed identity vote smoother. Frames go in
// through the item channel and verdicts come back on the result channel.
// Each verdict is compared field by field with a local vote-window
// predictor. The run covers several register settings, the register
// extremes among them, and several sender and receiver idle patterns,
// including one long receiver hold that backs the block up.
// ----------------------------------------------------------------------------
module windowed_identity_vote_smoother_test;
    import wivs_pkg::*;

    localparam int WIN_MAX = WINDOW_MAX_DEF;
    localparam int IDW     = ID_BITS_DEF;
    localparam int SCW     = SCORE_BITS_DEF;

    // This pause covers a clear or a record still in flight, even one over a
    // full known window.
    localparam int DRAIN_CYCLES  = 400;
    localparam int LONG_HOLD     = 3000;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_FRAMES  = 100;

    // Index with no register behind it; writes there must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic                  action;
        logic [IDW-1:0]        matched_id;
        logic [IDW-1:0]        nearest_id;
        logic signed [SCW-1:0] match_score;
    } frame_t;

    typedef struct packed {
        logic                  accepted;
        logic [IDW-1:0]        winner_id;
        logic [VOTE_BITS-1:0]  winner_votes;
        logic signed [SCW-1:0] winner_average;
    } verdict_t;

    // ------------------------------------------------------------------
    // Clock, reset and the bench-side copies of every block input. They
    // carry known values from time zero and reach the interfaces through
    // continuous assigns.
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    frame_t                   drv_frame = '0;
    logic                     drv_valid = 1'b0;
    logic                     rcv_ready = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_WINDOW_LENGTH;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    wivs_item_if   #(.ID_BITS(IDW), .SCORE_BITS(SCW)) item_ch ();
    wivs_result_if #(.ID_BITS(IDW), .SCORE_BITS(SCW)) result_ch ();
    wivs_cfg_if                                        cfg_ch ();

    assign item_ch.valid       = drv_valid;
    assign item_ch.action      = drv_frame.action;
    assign item_ch.matched_id  = drv_frame.matched_id;
    assign item_ch.nearest_id  = drv_frame.nearest_id;
    assign item_ch.match_score = drv_frame.match_score;
    assign result_ch.ready     = rcv_ready;
    assign cfg_ch.valid        = cfg_valid;
    assign cfg_ch.index        = cfg_index;
    assign cfg_ch.data         = cfg_data;

    windowed_identity_vote_smoother #(
        .WINDOW_MAX (WIN_MAX),
        .ID_BITS    (IDW),
        .SCORE_BITS (SCW)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Bench state shared between the stimulus, driver and monitor
    // ------------------------------------------------------------------
    frame_t   frame_queue[$];       // frames waiting for the driver
    verdict_t pending_verdicts[$];  // predicted verdicts, oldest first
    int       frames_queued   = 0;
    int       frames_taken    = 0;
    int       fail_count      = 0;
    int       cycle_count     = 0;
    logic     item_taken      = 1'b0;
    logic     cfg_taken       = 1'b0;
    int       send_idle_pct   = 0;
    int       recv_stall_pct  = 0;
    logic     long_hold_req   = 1'b0;
    int       hold_count      = 0;

    // ------------------------------------------------------------------
    // Vote-window predictor: its own ring, pointer, occupancy and copy of
    // the three registers, starting from their reset values.
    // ------------------------------------------------------------------
    logic [IDW-1:0]        ring_id    [WIN_MAX] = '{default: '0};
    logic signed [SCW-1:0] ring_score [WIN_MAX] = '{default: '0};
    int                    wr_ptr   = 0;
    int                    fill     = 0;
    logic [WLEN_BITS-1:0]  reg_wlen = WLEN_RST;
    logic [MINV_BITS-1:0]  reg_minv = MINV_RST;
    logic signed [THR_BITS-1:0] reg_thr = THR_RST;

    // Insert one record frame and work out the verdict of the new window.
    function automatic verdict_t record_frame(frame_t f);
        int             span, i, j, slot_i, slot_j;
        int             votes, sum, avg, lead_votes, best_avg;
        int             minv_val, thr_val;
        logic [IDW-1:0] cand, id, best_id;
        verdict_t       v;
        // length zero acts as one, anything past the ring saturates
        span = reg_wlen;
        if (span == 0)
            span = 1;
        if (span > WIN_MAX)
            span = WIN_MAX;
        // fall back to the nearest id when the recognizer rejected the face
        cand = (f.matched_id != '0) ? f.matched_id : f.nearest_id;
        ring_id[wr_ptr]    = cand;
        ring_score[wr_ptr] = f.match_score;
        wr_ptr = (wr_ptr + 1) % WIN_MAX;
        // a shrunk window drops its oldest entries here for good
        fill = (fill + 1 > span) ? span : fill + 1;
        best_id    = '0;
        lead_votes = 0;
        best_avg   = 0;
        for (i = 0; i < fill; i++)
        begin
            slot_i = (wr_ptr + WIN_MAX - 1 - i) % WIN_MAX;
            id     = ring_id[slot_i];
            if (id != '0)
            begin
                votes = 0;
                sum   = 0;
                for (j = 0; j < fill; j++)
                begin
                    slot_j = (wr_ptr + WIN_MAX - 1 - j) % WIN_MAX;
                    if (ring_id[slot_j] == id)
                    begin
                        votes++;
                        sum += ring_score[slot_j];
                    end
                end
                avg = sum / votes;  // truncates toward zero
                if (votes > lead_votes ||
                    (votes == lead_votes && avg > best_avg) ||
                    (votes == lead_votes && avg == best_avg && id < best_id))
                begin
                    best_id    = id;
                    lead_votes = votes;
                    best_avg   = avg;
                end
            end
        end
        minv_val = reg_minv;
        thr_val  = reg_thr;
        v.accepted       = (best_id != '0) && (lead_votes >= minv_val) &&
                           (best_avg >= thr_val);
        v.winner_id      = best_id;
        v.winner_votes   = lead_votes[VOTE_BITS-1:0];
        v.winner_average = best_avg[SCW-1:0];
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: samples every channel at the rising edge. Result check
    // comes before the prediction of a frame taken at the same edge, since
    // a verdict always belongs to an earlier frame.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        verdict_t want;
        verdict_t predicted;
        if (rst_n)
        begin
            item_taken <= drv_valid && item_ch.ready;
            cfg_taken  <= cfg_valid && cfg_ch.ready;

            if (cfg_valid && cfg_ch.ready)
            begin
                case (cfg_index)
                    CFG_WINDOW_LENGTH:    reg_wlen = cfg_data[WLEN_BITS-1:0];
                    CFG_MIN_VOTES:        reg_minv = cfg_data[MINV_BITS-1:0];
                    CFG_ACCEPT_THRESHOLD: reg_thr  = cfg_data[THR_BITS-1:0];
                    default: ;
                endcase
            end

            if (result_ch.valid && rcv_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("verdict transfer with nothing pending: winner_id %0d",
                           result_ch.winner_id);
                    fail_count++;
                end
                else
                begin
                    want = pending_verdicts[0];
                    pending_verdicts.delete(0);
                    if (result_ch.accepted !== want.accepted)
                    begin
                        $error("accepted: expected %0d, got %0d",
                               want.accepted, result_ch.accepted);
                        fail_count++;
                    end
                    if (result_ch.winner_id !== want.winner_id)
                    begin
                        $error("winner_id: expected %0d, got %0d",
                               want.winner_id, result_ch.winner_id);
                        fail_count++;
                    end
                    if (result_ch.winner_votes !== want.winner_votes)
                    begin
                        $error("winner_votes: expected %0d, got %0d",
                               want.winner_votes, result_ch.winner_votes);
                        fail_count++;
                    end
                    if (result_ch.winner_average !== want.winner_average)
                    begin
                        $error("winner_average: expected %0d, got %0d",
                               want.winner_average, result_ch.winner_average);
                        fail_count++;
                    end
                end
            end

            if (drv_valid && item_ch.ready)
            begin
                frames_taken++;
                if (drv_frame.action == ACT_CLEAR)
                begin
                    // clear empties the window and gives no verdict
                    wr_ptr = 0;
                    fill   = 0;
                end
                else
                begin
                    predicted        = record_frame(drv_frame);
                    pending_verdicts = {pending_verdicts, predicted};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: at the falling edge, once the current frame has gone through
    // (or none is up), either offers the next queued frame or idles.
    // valid stays high between back-to-back frames.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!drv_valid || item_taken))
        begin
            if (frame_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drv_frame <= frame_queue[0];
                frame_queue.delete(0);
                drv_valid <= 1'b1;
            end
            else
                drv_valid <= 1'b0;
        end
    end

    // Long receiver hold, counted here once the stimulus arms it.
    always @(negedge clk)
    begin
        if (long_hold_req && hold_count < LONG_HOLD)
            hold_count <= hold_count + 1;
    end

    // Receiver: random stalls, or flat off while the long hold runs.
    always @(negedge clk)
    begin
        rcv_ready <= !(long_hold_req && hold_count < LONG_HOLD) &&
                     ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_frame(logic act, logic [IDW-1:0] m,
                                        logic [IDW-1:0] nr, logic [SCW-1:0] s);
        frame_t f;
        f.action      = act;
        f.matched_id  = m;
        f.nearest_id  = nr;
        f.match_score = s;
        frame_queue = {frame_queue, f};
        frames_queued++;
    endfunction

    // One register write; returns at the falling edge after the transfer.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every frame to go through and every verdict to come back,
    // then let a clear or a verdict-less tail settle before touching
    // registers.
    task automatic drain_block();
        while (frames_taken != frames_queued || pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int                 p, n, r, pool_base;
        logic [15:0]        d;
        logic [IDW-1:0]     m, nr;
        logic [SCW-1:0]     s;
        logic [WLEN_BITS-1:0] wl;
        logic [MINV_BITS-1:0] mv;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset settings, no idling.
        queue_frame(ACT_RECORD, 8'd7,   8'd0,   16'h7FFF);   // top score
        queue_frame(ACT_RECORD, 8'd7,   8'd9,   16'd20000);  // matched wins over nearest
        queue_frame(ACT_RECORD, 8'd0,   8'd7,   16'd16384);  // nearest fallback
        queue_frame(ACT_RECORD, 8'd0,   8'd0,   16'h8000);   // unknown slot, bottom score
        queue_frame(ACT_RECORD, 8'd255, 8'd255, 16'h8000);
        queue_frame(ACT_RECORD, 8'd0,   8'd255, 16'h0000);   // evicts the oldest
        queue_frame(ACT_CLEAR,  8'd170, 8'd85,  16'h5555);
        queue_frame(ACT_RECORD, 8'd3,   8'd0,   16'hFFFD);   // -3
        queue_frame(ACT_RECORD, 8'd3,   8'd0,   16'hFFFE);   // -2: average -5/2 = -2
        queue_frame(ACT_RECORD, 8'd4,   8'd0,   16'd100);    // vote tie, higher average
        queue_frame(ACT_RECORD, 8'd4,   8'd0,   16'd100);
        queue_frame(ACT_CLEAR,  8'd0,   8'd0,   16'h0000);
        queue_frame(ACT_RECORD, 8'd9,   8'd0,   16'd1000);   // full tie, lower id wins
        queue_frame(ACT_RECORD, 8'd6,   8'd0,   16'd1000);
        queue_frame(ACT_RECORD, 8'd1,   8'd0,   16'd16383);  // average one below threshold
        queue_frame(ACT_RECORD, 8'd1,   8'd0,   16'd16383);
        queue_frame(ACT_RECORD, 8'd1,   8'd0,   16'd16384);
        drain_block();

        // Full ring, vote test off, threshold at its floor.
        write_reg(CFG_WINDOW_LENGTH, 16'hA5A8);
        write_reg(CFG_MIN_VOTES, 16'h0000);
        write_reg(CFG_ACCEPT_THRESHOLD, 16'h8000);
        @(posedge clk);
        for (n = 0; n < 8; n++)
            queue_frame(ACT_RECORD, 8'(1 + n % 3), 8'd0, 16'($urandom_range(0, 65535)));
        drain_block();

        // Shrink: the next record drops the oldest entries beyond two.
        write_reg(CFG_WINDOW_LENGTH, 16'd2);
        @(posedge clk);
        queue_frame(ACT_RECORD, 8'd2, 8'd0, 16'd500);
        queue_frame(ACT_RECORD, 8'd0, 8'd0, 16'd500);
        drain_block();

        // Grow again: dropped entries stay gone.
        write_reg(CFG_WINDOW_LENGTH, 16'd8);
        @(posedge clk);
        queue_frame(ACT_RECORD, 8'd3, 8'd0, 16'd700);
        queue_frame(ACT_RECORD, 8'd0, 8'd0, 16'd0);          // no known id with votes off
        drain_block();

        // Zero length acts as one; votes and threshold at their ceilings.
        write_reg(CFG_WINDOW_LENGTH, 16'hFFF0);
        write_reg(CFG_MIN_VOTES, 16'd15);
        write_reg(CFG_ACCEPT_THRESHOLD, 16'h7FFF);
        write_reg(CFG_UNUSED, 16'hFFFF);
        @(posedge clk);
        queue_frame(ACT_RECORD, 8'd5, 8'd0, 16'h7FFF);
        queue_frame(ACT_RECORD, 8'd0, 8'd0, 16'h7FFF);
        drain_block();

        // Random phases: each one a new register setting and idle pattern.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 6)
                0:       wl = 4'd8;
                1:       wl = 4'd1;
                2:       wl = 4'd0;
                3:       wl = 4'd15;
                default: wl = 4'($urandom_range(0, 15));
            endcase
            case (p % 5)
                0:       mv = 4'd0;
                1:       mv = 4'd1;
                2:       mv = 4'd8;
                3:       mv = 4'd15;
                default: mv = 4'($urandom_range(0, 15));
            endcase
            // upper data bits of the narrow registers are don't-care
            d = 16'($urandom_range(0, 65535));
            d[WLEN_BITS-1:0] = wl;
            write_reg(CFG_WINDOW_LENGTH, d);
            d = 16'($urandom_range(0, 65535));
            d[MINV_BITS-1:0] = mv;
            write_reg(CFG_MIN_VOTES, d);
            case (p % 4)
                0:       d = 16'h8000;
                1:       d = 16'h7FFF;
                2:       d = 16'($urandom_range(8000, 24000));
                default: d = 16'($urandom_range(0, 65535));
            endcase
            write_reg(CFG_ACCEPT_THRESHOLD, d);
            if (p == 6)
                write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));

            @(posedge clk);
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            // one long receiver hold while the sender keeps offering frames
            if (p == 4)
                long_hold_req = 1'b1;

            // a small pool of ids per phase so that votes pile up
            pool_base = $urandom_range(1, 252);
            for (n = 0; n < PHASE_FRAMES; n++)
            begin
                r = $urandom_range(99);
                if (r < 3)
                    queue_frame(ACT_CLEAR, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)),
                                16'($urandom_range(0, 65535)));
                else if (r < 15)
                    queue_frame(ACT_RECORD, 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)),
                                16'($urandom_range(0, 65535)));
                else
                begin
                    m  = ($urandom_range(99) < 65) ?
                         8'(pool_base + $urandom_range(0, 3)) : 8'd0;
                    nr = ($urandom_range(99) < 70) ?
                         8'(pool_base + $urandom_range(0, 3)) : 8'd0;
                    s  = ($urandom_range(99) < 75) ?
                         16'($urandom_range(10000, 30000)) :
                         16'($urandom_range(0, 65535));
                    queue_frame(ACT_RECORD, m, nr, s);
                end
            end
            drain_block();
        end

        if (fail_count == 0 && pending_verdicts.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
